// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SBQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBQ_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SBQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBQ_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/sbq_pkg.sv =====
`timescale 1ns / 1ps
package sbq_pkg;
	localparam int VECTOR_LENGTH_DEF = 128;
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int MAX_LEN           = 256;

	localparam logic [2:0] REG_REORDER  = 3'd0;
	localparam logic [2:0] REG_BAND_LOG = 3'd1;
	localparam logic [2:0] REG_BITS0    = 3'd2;
	localparam logic [2:0] REG_BITS1    = 3'd3;
	localparam logic [2:0] REG_BITS2    = 3'd4;
	localparam logic [2:0] REG_BITS3    = 3'd5;

	localparam logic       RST_REORDER  = 1'b1;
	localparam logic [1:0] RST_BAND_LOG = 2'd2;
	localparam logic [3:0] RST_BITS0    = 4'd5;
	localparam logic [3:0] RST_BITS1    = 4'd5;
	localparam logic [3:0] RST_BITS2    = 4'd4;
	localparam logic [3:0] RST_BITS3    = 4'd3;

	localparam logic [3:0]  BITS_MIN   = 4'd2;
	localparam logic [3:0]  BITS_MAX   = 4'd8;
	localparam logic [15:0] HALF_INF   = 16'h7C00;
	localparam int          HALF_BIAS  = 15;
	localparam int          HALF_TOP   = 46;
	localparam int          SCALE_SHIFT = 22;

	typedef logic [8*MAX_LEN-1:0] order_tab_t;

	// Squarefree indices first, then the rest, both ascending; index 0 is not squarefree.
	function automatic order_tab_t sqf_order(input int n);
		logic [MAX_LEN-1:0] nsf;
		order_tab_t t;
		int d;
		int m;
		int i;
		int w;
		nsf = '0;
		t = '0;
		w = 0;
		nsf[0] = 1'b1;
		for (d = 2; d * d < n; d++)
			for (m = d * d; m < n; m += d * d)
				nsf[m] = 1'b1;
		for (i = 0; i < n; i++)
			if (!nsf[i]) begin
				t[w*8 +: 8] = 8'(i);
				w++;
			end
		for (i = 0; i < n; i++)
			if (nsf[i]) begin
				t[w*8 +: 8] = 8'(i);
				w++;
			end
		return t;
	endfunction
endpackage

// ===== rtl/core/spectral_band_quantizer_unit.sv =====
`timescale 1ns / 1ps
// Walsh-Hadamard band quantizer.
// Input: sample_valid/sample_stall carry one signed sample word per element, in index
// order. sample_stall is low only while a vector is being loaded; one word a cycle.
// After the last sample the block works from its coefficient memory (one read and
// one write port, registered read): butterfly per pair as read a, read b, write
// a+b, write a-b; per band a peak scan, an fp16 scale divide, then per element
// read, multiply, 7-step divide, pack. The next vector is taken only after the
// last word of the record is issued.
// Output: record_valid/record_stall carry the record in 64-bit words, byte_count
// valid bytes each, last_word on the final word. The output register lets the
// block go on while a word waits; packing pauses while that word is stalled.
// Config: cfg_valid/cfg_ready (ready always high); write registers only when idle.
// Reset returns the registers to their defaults and starts loading at index 0.
`include "assert_macros.svh"
module spectral_band_quantizer_unit #(
	parameter int VECTOR_LENGTH = sbq_pkg::VECTOR_LENGTH_DEF,
	parameter int SAMPLE_BITS   = sbq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          record_valid,
	input  logic                          record_stall,
	output logic [63:0]                   record_bytes,
	output logic [3:0]                    byte_count,
	output logic                          last_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [3:0]                    cfg_data
);
	localparam int AW   = $clog2(VECTOR_LENGTH);
	localparam int CNTW = AW + 1;
	localparam int LW   = $clog2(AW);
	localparam int CW   = SAMPLE_BITS + AW;
	localparam int QW   = CW + sbq_pkg::SCALE_SHIFT;
	localparam int PW   = $clog2(QW);
	localparam int NW   = CW + 9;
	localparam bit IS_POW2 = ((1 << AW) == VECTOR_LENGTH);
	localparam sbq_pkg::order_tab_t ORDER = sbq_pkg::sqf_order(VECTOR_LENGTH);
	localparam logic [CNTW-1:0] NLEN = CNTW'(VECTOR_LENGTH);

	typedef enum logic [3:0] {
		S_LOAD, S_BF_RA, S_BF_RB, S_BF_WA, S_BF_WB, S_BAND, S_PK, S_HALF,
		S_HPUT, S_Q_RD, S_Q_MUL, S_Q_DIV, S_Q_PUT, S_PAD, S_FLUSH
	} state_t;

	state_t state_q;

	logic signed [CW-1:0] mem [VECTOR_LENGTH];
	logic signed [CW-1:0] rdata_q;
	logic                 we;
	logic [AW-1:0]        wa, ra;
	logic signed [CW-1:0] wd;

	logic           reorder_q;
	logic [1:0]     bclog_q;
	logic [3:0]     bits_q [4];

	logic [AW-1:0]   ld_q;
	logic [LW-1:0]   lvl_q;
	logic [AW-2:0]   pair_q;
	logic signed [CW-1:0] a_q, b_q;
	logic [1:0]      band_q;
	logic [CNTW-1:0] elem_q;
	logic            pkv_s1;
	logic [CW-1:0]   peak_q;
	logic [QW-1:0]   hdiv_q;
	logic [PW-1:0]   hk_q, hexp_q;
	logic [6:0]      hrem_q;
	logic            found_q;
	logic [3:0]      mcnt_q;
	logic [9:0]      mant_q;
	logic [NW-1:0]   num_q;
	logic            neg_q;
	logic [6:0]      r_q;
	logic [2:0]      dk_q;
	logic [79:0]     acc_q;
	logic [6:0]      fill_q;
	logic            rec_valid_q;
	logic [63:0]     rec_bytes_q;
	logic [3:0]      rec_count_q;
	logic            rec_last_q;

	logic [1:0]      lg_eff;
	logic [CNTW-1:0] bsize, start_w;
	logic [AW-1:0]   pos, addr;
	logic [3:0]      bits_raw, bits_eff;
	logic [6:0]      maxq;
	logic [AW-1:0]   pair_ext, bfa, bfb;
	logic [CW-1:0]   mag;
	logic            out_free;
	logic            put_en;
	logic [15:0]     put_val;
	logic [4:0]      put_w;
	logic [79:0]     acc_n;
	logic [6:0]      fill_n;
	logic [7:0]      r2;
	logic            qbit;
	logic [15:0]     half;
	logic [6:0]      rr;
	logic [7:0]      uval;
	logic [NW-1:0]   dsh;

	assign lg_eff   = (bclog_q == 2'd3) ? 2'd2 : bclog_q;
	assign bsize    = NLEN >> lg_eff;
	assign start_w  = CNTW'(band_q * bsize);
	assign pos      = AW'(start_w + elem_q);
	assign addr     = reorder_q ? AW'(ORDER[{pos, 3'b000} +: 8]) : pos;
	assign bits_raw = bits_q[band_q];
	assign bits_eff = (bits_raw < sbq_pkg::BITS_MIN) ? sbq_pkg::BITS_MIN :
		(bits_raw > sbq_pkg::BITS_MAX) ? sbq_pkg::BITS_MAX : bits_raw;
	assign maxq     = 7'((8'd1 << (bits_eff - 4'd1)) - 8'd1);

	// pair index with a zero bit inserted at the current level
	assign pair_ext = AW'(pair_q);
	assign bfa = ((pair_ext >> lvl_q) << (lvl_q + 1'b1)) |
		(pair_ext & ((AW'(1) << lvl_q) - AW'(1)));
	assign bfb = bfa | (AW'(1) << lvl_q);

	assign mag      = rdata_q[CW-1] ? CW'(-rdata_q) : CW'(rdata_q);
	assign out_free = !rec_valid_q || !record_stall;

	assign r2   = {hrem_q, hdiv_q[QW-1]};
	assign qbit = (r2 >= {1'b0, maxq});

	always_comb begin
		if (!found_q || hexp_q <= PW'(sbq_pkg::HALF_BIAS))
			half = '0;
		else if (hexp_q >= PW'(sbq_pkg::HALF_TOP))
			half = sbq_pkg::HALF_INF;
		else
			half = {1'b0, 5'(hexp_q - PW'(sbq_pkg::HALF_BIAS)), mant_q};
	end

	assign rr   = (peak_q == '0) ? 7'd0 : ((r_q > maxq) ? maxq : r_q);
	assign uval = neg_q ? 8'({1'b0, maxq} - {1'b0, rr}) : 8'({1'b0, maxq} + {1'b0, rr});
	assign dsh  = NW'({peak_q, 1'b0}) << dk_q;

	always_comb begin
		put_en  = 1'b0;
		put_val = '0;
		put_w   = '0;
		case (state_q)
			S_HPUT: begin
				put_en  = out_free;
				put_val = half;
				put_w   = 5'd16;
			end
			S_Q_PUT: begin
				put_en  = out_free;
				put_val = 16'(uval);
				put_w   = 5'(bits_eff);
			end
			default: ;
		endcase
	end
	assign acc_n  = acc_q | ({64'b0, put_val} << fill_q);
	assign fill_n = fill_q + 7'(put_w);

	always_comb begin
		we = 1'b0;
		wa = ld_q;
		wd = CW'(sample);
		ra = addr;
		case (state_q)
			S_LOAD:  we = sample_valid;
			S_BF_RA: ra = bfa;
			S_BF_RB: ra = bfb;
			S_BF_WA: begin
				we = 1'b1;
				wa = bfa;
				wd = a_q + rdata_q;
			end
			S_BF_WB: begin
				we = 1'b1;
				wa = bfb;
				wd = a_q - b_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			reorder_q   <= sbq_pkg::RST_REORDER;
			bclog_q     <= sbq_pkg::RST_BAND_LOG;
			bits_q[0]   <= sbq_pkg::RST_BITS0;
			bits_q[1]   <= sbq_pkg::RST_BITS1;
			bits_q[2]   <= sbq_pkg::RST_BITS2;
			bits_q[3]   <= sbq_pkg::RST_BITS3;
			ld_q        <= '0;
			lvl_q       <= '0;
			pair_q      <= '0;
			a_q         <= '0;
			b_q         <= '0;
			band_q      <= '0;
			elem_q      <= '0;
			pkv_s1      <= 1'b0;
			peak_q      <= '0;
			hdiv_q      <= '0;
			hk_q        <= '0;
			hexp_q      <= '0;
			hrem_q      <= '0;
			found_q     <= 1'b0;
			mcnt_q      <= '0;
			mant_q      <= '0;
			num_q       <= '0;
			neg_q       <= 1'b0;
			r_q         <= '0;
			dk_q        <= '0;
			acc_q       <= '0;
			fill_q      <= '0;
			rec_valid_q <= 1'b0;
			rec_bytes_q <= '0;
			rec_count_q <= '0;
			rec_last_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					sbq_pkg::REG_REORDER:  reorder_q <= cfg_data[0];
					sbq_pkg::REG_BAND_LOG: bclog_q   <= cfg_data[1:0];
					sbq_pkg::REG_BITS0:    bits_q[0] <= cfg_data;
					sbq_pkg::REG_BITS1:    bits_q[1] <= cfg_data;
					sbq_pkg::REG_BITS2:    bits_q[2] <= cfg_data;
					sbq_pkg::REG_BITS3:    bits_q[3] <= cfg_data;
					default: ;
				endcase
			end

			if (out_free)
				rec_valid_q <= 1'b0;
			if (put_en) begin
				if (fill_n > 7'd64) begin
					rec_valid_q <= 1'b1;
					rec_bytes_q <= acc_n[63:0];
					rec_count_q <= 4'd8;
					rec_last_q  <= 1'b0;
					acc_q       <= acc_n >> 64;
					fill_q      <= fill_n - 7'd64;
				end else begin
					acc_q  <= acc_n;
					fill_q <= fill_n;
				end
			end

			case (state_q)
				S_LOAD: begin
					if (sample_valid) begin
						if (ld_q == AW'(VECTOR_LENGTH - 1)) begin
							ld_q    <= '0;
							lvl_q   <= '0;
							pair_q  <= '0;
							band_q  <= '0;
							state_q <= IS_POW2 ? S_BF_RA : S_BAND;
						end else begin
							ld_q <= ld_q + 1'b1;
						end
					end
				end
				S_BF_RA: state_q <= S_BF_RB;
				S_BF_RB: begin
					a_q     <= rdata_q;
					state_q <= S_BF_WA;
				end
				S_BF_WA: begin
					b_q     <= rdata_q;
					state_q <= S_BF_WB;
				end
				S_BF_WB: begin
					pair_q <= pair_q + 1'b1;
					state_q <= S_BF_RA;
					if (pair_q == '1) begin
						if (lvl_q == LW'(AW - 1))
							state_q <= S_BAND;
						else
							lvl_q <= lvl_q + 1'b1;
					end
				end
				S_BAND: begin
					peak_q  <= '0;
					elem_q  <= '0;
					pkv_s1  <= 1'b0;
					state_q <= S_PK;
				end
				S_PK: begin
					pkv_s1 <= (elem_q < bsize);
					if (elem_q < bsize)
						elem_q <= elem_q + 1'b1;
					if (pkv_s1 && mag > peak_q)
						peak_q <= mag;
					if (elem_q == bsize && !pkv_s1) begin
						hdiv_q  <= {peak_q, {sbq_pkg::SCALE_SHIFT{1'b0}}};
						hk_q    <= PW'(QW - 1);
						hrem_q  <= '0;
						found_q <= 1'b0;
						hexp_q  <= '0;
						mcnt_q  <= '0;
						mant_q  <= '0;
						state_q <= S_HALF;
					end
				end
				S_HALF: begin
					// one quotient bit a cycle, MSB first; catch the leading one and 10 more
					hdiv_q <= hdiv_q << 1;
					hrem_q <= qbit ? 7'(r2 - {1'b0, maxq}) : r2[6:0];
					if (!found_q && qbit) begin
						found_q <= 1'b1;
						hexp_q  <= hk_q;
					end else if (found_q && mcnt_q < 4'd10) begin
						mant_q <= {mant_q[8:0], qbit};
						mcnt_q <= mcnt_q + 1'b1;
					end
					if (hk_q == '0)
						state_q <= S_HPUT;
					else
						hk_q <= hk_q - 1'b1;
				end
				S_HPUT: begin
					if (out_free) begin
						elem_q  <= '0;
						state_q <= S_Q_RD;
					end
				end
				S_Q_RD: state_q <= S_Q_MUL;
				S_Q_MUL: begin
					num_q   <= ((NW'(mag) * NW'(maxq)) << 1) + NW'(peak_q);
					neg_q   <= rdata_q[CW-1];
					r_q     <= '0;
					dk_q    <= 3'd6;
					state_q <= S_Q_DIV;
				end
				S_Q_DIV: begin
					if (num_q >= dsh) begin
						num_q     <= num_q - dsh;
						r_q[dk_q] <= 1'b1;
					end
					if (dk_q == '0)
						state_q <= S_Q_PUT;
					else
						dk_q <= dk_q - 1'b1;
				end
				S_Q_PUT: begin
					if (out_free) begin
						elem_q <= elem_q + 1'b1;
						if (CNTW'(elem_q + 1'b1) == bsize)
							state_q <= S_PAD;
						else
							state_q <= S_Q_RD;
					end
				end
				S_PAD: begin
					// close the band on a byte boundary
					fill_q <= (fill_q + 7'd7) & ~7'd7;
					if (band_q == 2'((3'd1 << lg_eff) - 3'd1)) begin
						state_q <= S_FLUSH;
					end else begin
						band_q  <= band_q + 1'b1;
						state_q <= S_BAND;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						rec_valid_q <= 1'b1;
						rec_bytes_q <= acc_q[63:0];
						rec_count_q <= 4'(fill_q >> 3);
						rec_last_q  <= 1'b1;
						acc_q       <= '0;
						fill_q      <= '0;
						band_q      <= '0;
						state_q     <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign sample_stall = (state_q != S_LOAD);
	assign cfg_ready    = 1'b1;
	assign record_valid = rec_valid_q;
	assign record_bytes = rec_bytes_q;
	assign byte_count   = rec_count_q;
	assign last_word    = rec_last_q;

	`SBQ_ASSERT(a_fill_bound, clk, arst_n, fill_q <= 7'd64, "pack fill above one word")
	`SBQ_ASSERT(a_short_is_last, clk, arst_n, rec_valid_q && (rec_count_q != 4'd8) |-> rec_last_q, "short word not last")
	`SBQ_ASSERT(a_scale_rem, clk, arst_n, (state_q == S_HALF) |-> (hrem_q < maxq), "scale remainder out of range")
	`SBQ_NEVER(a_div_range, clk, arst_n, (state_q == S_Q_DIV) && (peak_q != '0) && (num_q >= (dsh << 1)), "quotient bit overflow")
endmodule

// ===== tb/tb_spectral_band_quantizer_unit.sv =====
`timescale 1ns / 1ps
module tb_spectral_band_quantizer_unit;
	import sbq_pkg::*;

	localparam int VLEN = VECTOR_LENGTH_DEF;

	typedef struct {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic        last;
	} record_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	logic signed [15:0] sample = '0;
	logic               record_valid;
	logic               record_stall = 1'b0;
	logic [63:0]        record_bytes;
	logic [3:0]         byte_count;
	logic               last_word;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [3:0]         cfg_data = '0;

	// shadow of the block's registers
	logic       sh_reorder = RST_REORDER;
	logic [1:0] sh_band_log = RST_BAND_LOG;
	logic [3:0] sh_bits [4] = '{RST_BITS0, RST_BITS1, RST_BITS2, RST_BITS3};

	longint       loaded [VLEN];
	int           load_pos = 0;
	record_word_t pending_words [$];
	int           errors = 0;
	int           words_seen = 0;
	int           vectors_sent = 0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;

	spectral_band_quantizer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.record_valid(record_valid), .record_stall(record_stall),
		.record_bytes(record_bytes), .byte_count(byte_count), .last_word(last_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bit is_squarefree(int i);
		if (i == 0)
			return 1'b0;
		for (int d = 2; d * d <= i; d++)
			if (i % (d * d) == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [15:0] half_scale(longint unsigned peak, int maxq);
		logic [63:0] q;
		int p;
		int biased;
		p = -1;
		if (peak == 0)
			return 16'h0000;
		q = (peak << 30) / (longint'(maxq) << 8);
		for (int k = 63; k >= 0; k--)
			if (q[k] && p < 0)
				p = k;
		if (p < 0)
			return 16'h0000;
		biased = p - HALF_BIAS;
		if (biased <= 0)
			return 16'h0000;
		if (biased >= 31)
			return HALF_INF;
		return {1'b0, 5'(biased), 10'((q >> (p - 10)) & 64'h3FF)};
	endfunction

	// transform, reorder, band and pack the loaded vector into expected words
	task automatic predict_record();
		longint         coef [VLEN];
		longint         tmp [VLEN];
		logic [7:0]     rec [$];
		longint unsigned peak, mag, r;
		int             w, lg, nb, bs, bits, maxq, fill, u;
		logic [31:0]    acc;
		logic [15:0]    half;
		record_word_t   wd;
		coef = loaded;
		for (int span = 1; span < VLEN; span <<= 1)
			for (int base = 0; base < VLEN; base += span << 1)
				for (int j = 0; j < span; j++) begin
					longint a, b;
					a = coef[base + j];
					b = coef[base + j + span];
					coef[base + j] = a + b;
					coef[base + j + span] = a - b;
				end
		if (sh_reorder) begin
			w = 0;
			for (int i = 0; i < VLEN; i++)
				if (is_squarefree(i)) tmp[w++] = coef[i];
			for (int i = 0; i < VLEN; i++)
				if (!is_squarefree(i)) tmp[w++] = coef[i];
			coef = tmp;
		end
		lg = sh_band_log > 2 ? 2 : sh_band_log;
		nb = 1 << lg;
		bs = VLEN / nb;
		for (int b = 0; b < nb; b++) begin
			bits = sh_bits[b];
			if (bits < BITS_MIN) bits = BITS_MIN;
			if (bits > BITS_MAX) bits = BITS_MAX;
			maxq = (1 << (bits - 1)) - 1;
			peak = 0;
			for (int i = 0; i < bs; i++) begin
				mag = coef[b*bs + i] < 0 ? -coef[b*bs + i] : coef[b*bs + i];
				if (mag > peak) peak = mag;
			end
			half = half_scale(peak, maxq);
			rec.push_back(half[7:0]);
			rec.push_back(half[15:8]);
			acc = 0;
			fill = 0;
			for (int i = 0; i < bs; i++) begin
				mag = coef[b*bs + i] < 0 ? -coef[b*bs + i] : coef[b*bs + i];
				r = 0;
				if (peak != 0) r = (2 * mag * maxq + peak) / (2 * peak);
				if (r > maxq) r = maxq;
				u = coef[b*bs + i] < 0 ? maxq - int'(r) : maxq + int'(r);
				acc |= u << fill;
				fill += bits;
				while (fill >= 8) begin
					rec.push_back(acc[7:0]);
					acc >>= 8;
					fill -= 8;
				end
			end
			if (fill > 0) rec.push_back(acc[7:0]);
		end
		for (int pos = 0; pos < rec.size(); pos += 8) begin
			wd.bytes = '0;
			wd.count = (rec.size() - pos > 8) ? 8 : rec.size() - pos;
			for (int k = 0; k < wd.count; k++)
				wd.bytes[8*k +: 8] = rec[pos + k];
			wd.last = (pos + 8 >= rec.size());
			pending_words.push_back(wd);
		end
	endtask

	task automatic send_sample(input logic signed [15:0] v);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (sample_stall);
		loaded[load_pos] = v;
		load_pos++;
		if (load_pos == VLEN) begin
			load_pos = 0;
			predict_record();
		end
	endtask

	task automatic send_vector(input logic signed [15:0] vals [VLEN]);
		case (vectors_sent % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 59; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 59; end
			default: begin send_idle_pct = 32; stall_pct = 32; end
		endcase
		for (int i = 0; i < VLEN; i++)
			send_sample(vals[i]);
		sample_valid <= 1'b0;
		vectors_sent++;
	endtask

	// hold until the block has drained, then write all six registers
	task automatic write_config(input logic re, input logic [1:0] lg,
			input logic [3:0] b0, input logic [3:0] b1,
			input logic [3:0] b2, input logic [3:0] b3);
		logic [3:0] vals [6];
		logic [2:0] idx [6];
		vals = '{{3'b0, re}, {2'b0, lg}, b0, b1, b2, b3};
		idx = '{REG_REORDER, REG_BAND_LOG, REG_BITS0, REG_BITS1, REG_BITS2, REG_BITS3};
		wait (pending_words.size() == 0);
		repeat (20) @(posedge clk);
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		sh_reorder = re;
		sh_band_log = lg;
		sh_bits = '{b0, b1, b2, b3};
	endtask

	task automatic test_zero_peak();
		logic signed [15:0] v [VLEN];
		foreach (v[i]) v[i] = 16'sd0;
		send_vector(v);
	endtask

	// a unit impulse gives every coefficient magnitude 1: scale underflows
	task automatic test_tiny_scale();
		logic signed [15:0] v [VLEN];
		foreach (v[i]) v[i] = 16'sd0;
		v[0] = 16'sd1;
		write_config(1'b1, 2'd0, 4'd8, 4'd8, 4'd8, 4'd8);
		send_vector(v);
	endtask

	task automatic test_extremes();
		logic signed [15:0] v [VLEN];
		foreach (v[i]) v[i] = i[0] ? 16'sh7FFF : 16'sh8000;
		v[1] = 16'sd1;
		v[2] = -16'sd1;
		v[5] = 16'sd0;
		// band count out of range, widths below and above the legal span
		write_config(1'b0, 2'd3, 4'd0, 4'd1, 4'd9, 4'd15);
		send_vector(v);
		write_config(1'b1, 2'd1, 4'd2, 4'd8, 4'd2, 4'd8);
		send_vector(v);
	endtask

	task automatic test_random_vectors();
		logic signed [15:0] v [VLEN];
		int shift_top;
		for (int n = 0; n < 5; n++) begin
			write_config($urandom_range(1), $urandom_range(3), $urandom_range(15),
				$urandom_range(15), $urandom_range(15), $urandom_range(15));
			shift_top = $urandom_range(15);
			foreach (v[i]) begin
				v[i] = $urandom;
				v[i] = v[i] >>> $urandom_range(shift_top);
				if ($urandom_range(9) == 0) v[i] = 16'sd0;
			end
			send_vector(v);
		end
	endtask

	always @(posedge clk)
		if (arst_n)
			record_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		record_word_t e;
		if (arst_n && record_valid && !record_stall) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %h/%0d/%0b",
					$time, record_bytes, byte_count, last_word);
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (record_bytes !== e.bytes) begin
					$display("%0t: record_bytes expected %h actual %h",
						$time, e.bytes, record_bytes);
					errors++;
				end
				if (byte_count !== e.count) begin
					$display("%0t: byte_count expected %0d actual %0d",
						$time, e.count, byte_count);
					errors++;
				end
				if (last_word !== e.last) begin
					$display("%0t: last_word expected %0b actual %0b",
						$time, e.last, last_word);
					errors++;
				end
			end
		end
	end

	initial begin
		int waited;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_peak();
		test_tiny_scale();
		test_extremes();
		test_random_vectors();
		waited = 0;
		while (pending_words.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (pending_words.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, pending_words.size());
			errors++;
		end
		$display("Covered %0d vectors (%0d samples) and %0d record words under", vectors_sent,
			vectors_sent * VLEN, words_seen);
		$display("several band setups, idle and stall mixes.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout reached");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== spectral_band_quantizer_unit.f =====
+incdir+rtl/core
rtl/core/sbq_pkg.sv
rtl/core/spectral_band_quantizer_unit.sv
tb/tb_spectral_band_quantizer_unit.sv
